### sv/rsas_pkg.sv
// Shared types, command codes and node update function for the range set/add/sum tree.
package rsas_pkg;

    localparam logic [1:0] CMD_ASSIGN = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_SUM    = 2'd2;

    localparam int unsigned VAL_W = 64;
    localparam int unsigned OPD_W = 48;

    // One tree node: interval sum plus the lazy tag held for its children.
    // A set flag means lazy is an assign value, otherwise it is a pending add.
    typedef struct packed {
        logic [VAL_W-1:0] sum;
        logic [VAL_W-1:0] lazy;
        logic             asg;
    } t_node;

    localparam int unsigned NODE_W = $bits(t_node);

    // Apply an assign or an add of v to a node; vs is v times the node length.
    function automatic t_node node_apply(t_node n, logic [VAL_W-1:0] v,
                                         logic [VAL_W-1:0] vs, logic asg_op);
        t_node q;
        q = n;
        if (asg_op) begin
            q.sum  = vs;
            q.lazy = v;
            q.asg  = 1'b1;
        end else begin
            q.sum  = n.sum + vs;
            q.lazy = n.lazy + v;
        end
        return q;
    endfunction

endpackage

### sv/rsas_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module rsas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/range_set_add_sum_tree_top.sv
// Top level: lazy segment tree with range assign, range add and range sum.
//
// Usage: drive i_cmd, i_range_start, i_range_end and i_operand with start high;
// the word is taken at a clock edge where start is high and busy is low.
// Commands: assign and add change the range and give no result; a sum query
// gives one result word on o_range_sum, marked by o_valid for one cycle.
// The receiver cannot stall; o_valid is a single-cycle strobe.
// Flow: an empty range or unused command is handled in idle and busy never
// rises. Otherwise the tree walk runs on one node RAM (one read and one
// write port, registered read) and sets the rate: a push down each boundary
// node (two per level), then a visit of each covered node level by level,
// then for updates a pull of the child sums back up each boundary node.
// Nodes without a pending tag skip the child writes of the push.
// Reset (synchronous, active low) starts a clearing pass that writes every
// one of the 2*2^L node entries to zero, one per cycle; busy stays high
// until it is done (2048 entries at NUM_ELEMENTS = 1024).
module range_set_add_sum_tree_top #(
    parameter int NUM_ELEMENTS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [10:0] i_range_start,
    input  logic [10:0] i_range_end,
    input  logic signed [47:0] i_operand,
    output logic        o_valid,
    output logic signed [63:0] o_range_sum
);

    localparam int LVL    = $clog2(NUM_ELEMENTS);
    localparam int LEAVES = 1 << LVL;
    localparam int DEPTH  = 2 * LEAVES;
    localparam int AW     = LVL + 1;
    localparam int PW     = LVL + 2;
    localparam int HW     = $clog2(LVL + 1);
    localparam int WW     = (PW > 11) ? PW : 11;
    localparam int VW     = rsas_pkg::VAL_W;

    typedef enum logic [3:0] {
        ST_CLR, ST_IDLE,
        ST_PUSH_CHK, ST_PUSH_K, ST_PUSH_C0, ST_PUSH_C1, ST_PUSH_P,
        ST_AP_CHK, ST_AP_WR,
        ST_PL_CHK, ST_PL_C0, ST_PL_C1
    } t_state;

    t_state           r_state;
    logic [AW-1:0]    r_clr;
    logic             r_asg;
    logic             r_qry;
    logic [VW-1:0]    r_x;
    logic [PW-1:0]    r_l;
    logic [PW-1:0]    r_r;
    logic [PW-1:0]    r_ql;
    logic [PW-1:0]    r_qr;
    logic [HW-1:0]    r_h;
    logic [HW-1:0]    r_i;
    logic             r_side;
    logic [AW-1:0]    r_node;
    logic [VW-1:0]    r_plz;
    logic             r_pfl;
    logic [VW-1:0]    r_psum;
    logic [VW-1:0]    r_s0;
    logic [VW-1:0]    r_acc;

    rsas_pkg::t_node  rd;
    rsas_pkg::t_node  wdata;
    logic             we;
    logic             re;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;

    logic [WW-1:0]    a_w;
    logic [WW-1:0]    b_w;
    logic [WW-1:0]    b_clip;
    logic             empty;
    logic [PW-1:0]    mask_i;
    logic             cond;
    logic [AW-1:0]    cur_node;
    logic [AW-1:0]    child0;
    logic [AW-1:0]    child1;
    logic [AW-1:0]    cur_child0;
    logic [PW-1:0]    qr_dec;
    logic [VW-1:0]    plz_s;
    logic [VW-1:0]    x_s;
    logic             push_last;
    logic             pull_last;
    logic             has_lazy;

    rsas_ram #(
        .WIDTH (rsas_pkg::NODE_W),
        .DEPTH (DEPTH)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rd)
    );

    assign busy = (r_state != ST_IDLE);

    // range clipped to the array
    assign a_w    = WW'(i_range_start);
    assign b_w    = WW'(i_range_end);
    assign b_clip = (b_w > WW'(NUM_ELEMENTS)) ? WW'(NUM_ELEMENTS) : b_w;
    assign empty  = (a_w >= b_clip);

    assign mask_i     = (PW'(1) << r_i) - PW'(1);
    assign cond       = r_side ? |(r_r & mask_i) : |(r_l & mask_i);
    assign cur_node   = r_side ? AW'((r_r - PW'(1)) >> r_i) : AW'(r_l >> r_i);
    assign child0     = {r_node[AW-2:0], 1'b0};
    assign child1     = {r_node[AW-2:0], 1'b1};
    assign cur_child0 = {cur_node[AW-2:0], 1'b0};
    assign qr_dec     = r_qr - PW'(1);
    assign plz_s      = r_plz << (r_i - HW'(1));
    assign x_s        = r_x << r_h;
    assign push_last  = r_side && (r_i == HW'(1));
    assign pull_last  = r_side && (r_i == HW'(LVL));
    assign has_lazy   = rd.asg || (rd.lazy != '0);

    always_comb begin
        we    = 1'b0;
        waddr = r_node;
        wdata = '0;
        re    = 1'b0;
        raddr = cur_node;
        unique case (r_state)
            ST_CLR: begin
                we    = 1'b1;
                waddr = r_clr;
            end
            ST_PUSH_CHK: begin
                re = cond;
            end
            ST_PUSH_K: begin
                re    = has_lazy;
                raddr = child0;
            end
            ST_PUSH_C0: begin
                we    = 1'b1;
                waddr = child0;
                wdata = rsas_pkg::node_apply(rd, r_plz, plz_s, r_pfl);
                re    = 1'b1;
                raddr = child1;
            end
            ST_PUSH_C1: begin
                we    = 1'b1;
                waddr = child1;
                wdata = rsas_pkg::node_apply(rd, r_plz, plz_s, r_pfl);
            end
            ST_PUSH_P: begin
                we         = 1'b1;
                wdata.sum  = r_psum;
            end
            ST_AP_CHK: begin
                re    = (r_ql < r_qr) && (r_ql[0] || r_qr[0]);
                raddr = r_ql[0] ? r_ql[AW-1:0] : qr_dec[AW-1:0];
            end
            ST_AP_WR: begin
                we    = !r_qry;
                wdata = rsas_pkg::node_apply(rd, r_x, x_s, r_asg);
            end
            ST_PL_CHK: begin
                re    = cond;
                raddr = cur_child0;
            end
            ST_PL_C0: begin
                re    = 1'b1;
                raddr = child1;
            end
            ST_PL_C1: begin
                we        = 1'b1;
                wdata.sum = r_s0 + rd.sum;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_clr   <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                ST_CLR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == '1) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (start) begin
                        r_asg  <= (i_cmd == rsas_pkg::CMD_ASSIGN);
                        r_qry  <= (i_cmd == rsas_pkg::CMD_SUM);
                        r_x    <= VW'(i_operand);
                        r_l    <= PW'(LEAVES) + PW'(a_w);
                        r_r    <= PW'(LEAVES) + PW'(b_clip);
                        r_ql   <= PW'(LEAVES) + PW'(a_w);
                        r_qr   <= PW'(LEAVES) + PW'(b_clip);
                        r_h    <= '0;
                        r_i    <= HW'(LVL);
                        r_side <= 1'b0;
                        r_acc  <= '0;
                        unique case (i_cmd) inside
                            rsas_pkg::CMD_ASSIGN, rsas_pkg::CMD_ADD: begin
                                if (!empty) begin
                                    r_state <= ST_PUSH_CHK;
                                end
                            end
                            rsas_pkg::CMD_SUM: begin
                                if (empty) begin
                                    o_valid     <= 1'b1;
                                    o_range_sum <= '0;
                                end else begin
                                    r_state <= ST_PUSH_CHK;
                                end
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_PUSH_CHK: begin
                    if (cond) begin
                        r_node  <= cur_node;
                        r_state <= ST_PUSH_K;
                    end else begin
                        r_side  <= ~r_side;
                        if (r_side) r_i <= r_i - HW'(1);
                        r_state <= push_last ? ST_AP_CHK : ST_PUSH_CHK;
                    end
                end
                ST_PUSH_K: begin
                    r_plz  <= rd.lazy;
                    r_pfl  <= rd.asg;
                    r_psum <= rd.sum;
                    if (has_lazy) begin
                        r_state <= ST_PUSH_C0;
                    end else begin
                        r_side  <= ~r_side;
                        if (r_side) r_i <= r_i - HW'(1);
                        r_state <= push_last ? ST_AP_CHK : ST_PUSH_CHK;
                    end
                end
                ST_PUSH_C0: begin
                    r_state <= ST_PUSH_C1;
                end
                ST_PUSH_C1: begin
                    r_state <= ST_PUSH_P;
                end
                ST_PUSH_P: begin
                    r_side  <= ~r_side;
                    if (r_side) r_i <= r_i - HW'(1);
                    r_state <= push_last ? ST_AP_CHK : ST_PUSH_CHK;
                end
                ST_AP_CHK: begin
                    if (r_ql >= r_qr) begin
                        if (r_qry) begin
                            o_valid     <= 1'b1;
                            o_range_sum <= r_acc;
                            r_state     <= ST_IDLE;
                        end else begin
                            r_i     <= HW'(1);
                            r_side  <= 1'b0;
                            r_state <= ST_PL_CHK;
                        end
                    end else if (r_ql[0]) begin
                        r_node  <= r_ql[AW-1:0];
                        r_ql    <= r_ql + PW'(1);
                        r_state <= ST_AP_WR;
                    end else if (r_qr[0]) begin
                        r_node  <= qr_dec[AW-1:0];
                        r_qr    <= qr_dec;
                        r_state <= ST_AP_WR;
                    end else begin
                        r_ql <= r_ql >> 1;
                        r_qr <= r_qr >> 1;
                        r_h  <= r_h + HW'(1);
                    end
                end
                ST_AP_WR: begin
                    if (r_qry) r_acc <= r_acc + rd.sum;
                    r_state <= ST_AP_CHK;
                end
                ST_PL_CHK: begin
                    if (cond) begin
                        r_node  <= cur_node;
                        r_state <= ST_PL_C0;
                    end else begin
                        r_side  <= ~r_side;
                        if (r_side) r_i <= r_i + HW'(1);
                        r_state <= pull_last ? ST_IDLE : ST_PL_CHK;
                    end
                end
                ST_PL_C0: begin
                    r_s0    <= rd.sum;
                    r_state <= ST_PL_C1;
                end
                ST_PL_C1: begin
                    r_side  <= ~r_side;
                    if (r_side) r_i <= r_i + HW'(1);
                    r_state <= pull_last ? ST_IDLE : ST_PL_CHK;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### tb/tb_range_set_add_sum_tree_top.sv
// Testbench for the range set/add/sum tree: random and directed commands, flat-array predictor.
`timescale 1ns / 100ps

module tb_range_set_add_sum_tree_top;

    localparam int N_ELEM    = 1024;
    localparam int N_RANDOM  = 1130;
    localparam int WDOG_MAX  = 20000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  cmd;
        logic [10:0] first;
        logic [10:0] last;
        logic [47:0] opd;
    } t_cmd_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_cmd;
    logic [10:0] i_range_start;
    logic [10:0] i_range_end;
    logic signed [47:0] i_operand;
    logic        o_valid;
    logic signed [63:0] o_range_sum;

    range_set_add_sum_tree_top #(.NUM_ELEMENTS(N_ELEM)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .i_range_start(i_range_start), .i_range_end(i_range_end),
        .i_operand(i_operand), .o_valid(o_valid), .o_range_sum(o_range_sum)
    );

    // A flat array gives the same sums as the lazy tree: all arithmetic wraps mod 2^64.
    logic [63:0] elem_val [N_ELEM];
    t_cmd_word   cmd_queue [$];
    logic [63:0] sum_expected [$];
    int          n_fail = 0;
    int          n_sums = 0;
    int          n_cmds = 0;
    int          idle_left = 0;
    int          wdog = 0;
    bit          stim_done = 1'b0;
    bit          quiet = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] predict_word(t_cmd_word w);
        logic [63:0] x;
        logic [63:0] acc;
        x   = {{16{w.opd[47]}}, w.opd};
        acc = '0;
        for (int i = 0; i < N_ELEM; i++) begin
            if (i >= w.first && i < w.last) begin
                if (w.cmd == rsas_pkg::CMD_ASSIGN) elem_val[i] = x;
                else if (w.cmd == rsas_pkg::CMD_ADD) elem_val[i] = elem_val[i] + x;
                else if (w.cmd == rsas_pkg::CMD_SUM) acc = acc + elem_val[i];
            end
        end
        return acc;
    endfunction

    function automatic logic [47:0] rand_opd();
        case ($urandom_range(0, 4))
            0: return 48'h7FFF_FFFF_FFFF;
            1: return 48'h8000_0000_0000;
            2: return 48'($signed($urandom_range(0, 20)) - 10);
            default: return 48'({$urandom(), $urandom()});
        endcase
    endfunction

    function automatic t_cmd_word mk(logic [1:0] c, int a, int b, logic [47:0] x);
        t_cmd_word w;
        w.cmd = c; w.first = 11'(a); w.last = 11'(b); w.opd = x;
        return w;
    endfunction

    task automatic queue_word(t_cmd_word w);
        cmd_queue.insert(cmd_queue.size(), w);
    endtask

    // Mostly short ranges keep the tree walk cheap; some span wide or run past the end.
    function automatic t_cmd_word rand_word();
        int a;
        int len;
        logic [1:0] c;
        c = 2'($urandom_range(0, 2));
        if ($urandom_range(0, 40) == 0) c = CMD_UNUSED;
        case ($urandom_range(0, 9))
            0: begin a = $urandom_range(0, 2047); len = $urandom_range(0, 2047); end
            1, 2: begin a = $urandom_range(0, 200); len = $urandom_range(500, 1024); end
            3: begin a = $urandom_range(1000, 1024); len = $urandom_range(0, 30); end
            default: begin a = $urandom_range(0, 1023); len = $urandom_range(0, 64); end
        endcase
        return mk(c, a, (a + len) & 11'h7FF, rand_opd());
    endfunction

    initial begin
        for (int i = 0; i < N_ELEM; i++) elem_val[i] = '0;
        queue_word(mk(rsas_pkg::CMD_SUM, 0, 1024, '0));
        queue_word(mk(rsas_pkg::CMD_ASSIGN, 0, 1024, 48'h8000_0000_0000));
        queue_word(mk(rsas_pkg::CMD_SUM, 0, 1024, '0));
        queue_word(mk(rsas_pkg::CMD_ADD, 0, 2047, 48'h7FFF_FFFF_FFFF));
        queue_word(mk(rsas_pkg::CMD_SUM, 1023, 2047, '0));
        queue_word(mk(rsas_pkg::CMD_ASSIGN, 5, 5, 48'h1234));
        queue_word(mk(rsas_pkg::CMD_ADD, 9, 3, 48'h1));
        queue_word(mk(rsas_pkg::CMD_SUM, 700, 2, 48'hFFFF_FFFF_FFFF));
        queue_word(mk(CMD_UNUSED, 0, 1024, 48'h5555_AAAA_5555));
        queue_word(mk(rsas_pkg::CMD_ASSIGN, 1024, 2047, 48'h77));
        queue_word(mk(rsas_pkg::CMD_SUM, 1024, 2047, '0));
        // assigned value equal to the old sentinel must stick
        queue_word(mk(rsas_pkg::CMD_ASSIGN, 100, 300, 48'h0DE0_B6B3_A764));
        queue_word(mk(rsas_pkg::CMD_ADD, 150, 400, 48'hFFFF_FFFF_FFFF));
        queue_word(mk(rsas_pkg::CMD_SUM, 120, 350, '0));
        queue_word(mk(rsas_pkg::CMD_ADD, 0, 1, 48'hAAAA_AAAA_AAAA));
        queue_word(mk(rsas_pkg::CMD_ADD, 1023, 1024, 48'h5555_5555_5555));
        queue_word(mk(rsas_pkg::CMD_SUM, 0, 1, '0));
        queue_word(mk(rsas_pkg::CMD_SUM, 1023, 1024, '0));
        queue_word(mk(rsas_pkg::CMD_SUM, 1, 1023, '0));
        for (int i = 0; i < N_RANDOM; i++) queue_word(rand_word());
    end

    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_cmd         = '0;
        i_range_start = '0;
        i_range_end   = '0;
        i_operand     = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: holds a word until busy is low at the edge, random idle bursts between.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            quiet <= cmd_queue.size() < 150;
            if (start && !busy) begin
                n_cmds <= n_cmds + 1;
            end
            if (start && busy) begin
                // word still waiting
            end else if (idle_left > 0) begin
                start     <= 1'b0;
                idle_left <= idle_left - 1;
            end else if (cmd_queue.size() > 0 && !quiet && $urandom_range(0, 7) == 0) begin
                start     <= 1'b0;
                idle_left <= $urandom_range(1, 9);
            end else if (cmd_queue.size() > 0) begin
                t_cmd_word w;
                w = cmd_queue.pop_front();
                start         <= 1'b1;
                i_cmd         <= w.cmd;
                i_range_start <= w.first;
                i_range_end   <= w.last;
                i_operand     <= w.opd;
            end else begin
                start     <= 1'b0;
                stim_done <= 1'b1;
            end
        end
    end

    // Prediction at acceptance, from the values on the ports.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            logic [63:0] s;
            s = predict_word(mk(i_cmd, i_range_start, i_range_end, i_operand));
            if (i_cmd == rsas_pkg::CMD_SUM) sum_expected.insert(sum_expected.size(), s);
        end
    end

    // Monitor: results cannot be stalled, so each strobe is checked as it comes.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (sum_expected.size() == 0) begin
                $error("unexpected sum word: range_sum actual %0d", o_range_sum);
                n_fail <= n_fail + 1;
            end else begin
                logic [63:0] e;
                e = sum_expected.pop_front();
                if (o_range_sum !== e) begin
                    $error("range_sum mismatch: expected %0d actual %0d",
                           $signed(e), o_range_sum);
                    n_fail <= n_fail + 1;
                end
                n_sums <= n_sums + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) wdog <= 0;
        else wdog <= wdog + 1;
    end

    initial begin
        fork
            begin
                wait (stim_done && sum_expected.size() == 0);
                repeat (200) @(posedge i_clk);
            end
            begin
                wait (wdog >= WDOG_MAX);
            end
        join_any
        if (wdog >= WDOG_MAX) begin
            $display("watchdog expired with %0d sums outstanding", sum_expected.size());
            $display("** range_set_add_sum_tree_top: FAILED **");
            $finish;
        end else begin
            $display("%0d commands accepted (assign, add, query, unused), %0d sums checked",
                     n_cmds, n_sums);
            if (n_fail == 0 && sum_expected.size() == 0)
                $display("** range_set_add_sum_tree_top: PASSED **");
            else
                $display("** range_set_add_sum_tree_top: FAILED **");
            $finish;
        end
    end

endmodule
